// ===== rtl/core/slrg_pkg.sv =====
// Shared types and constants for the shuffled Lehmer random generator.
package slrg_pkg;

   // Shuffle table geometry.
   localparam int TABLE_SIZE = 32;
   localparam int IDX_W      = $clog2(TABLE_SIZE);

   // Datapath widths: signed generator word, 31-bit values, 15-bit multiplier.
   localparam int WORD_W  = 32;
   localparam int VALUE_W = 31;
   localparam int MUL_W   = 15;
   localparam int PROD_W  = WORD_W + MUL_W;
   localparam int HIGH_W  = PROD_W - VALUE_W;

   // Warm-up length of a reinitialization and its step counter width.
   localparam int WARMUP_STEPS = TABLE_SIZE + 8;
   localparam int CNT_W        = $clog2(WARMUP_STEPS);

   // Lehmer constants: multiplier 16807, modulus 2^31-1.
   localparam logic [MUL_W-1:0]  LEHMER_MUL = 15'd16807;
   localparam logic [WORD_W-1:0] LEHMER_MOD = 32'h7FFF_FFFF;

   // The table entry is picked by the top bits of the previous output.
   localparam int PICK_SHIFT = 26;

   // Request modes.
   localparam logic MODE_DRAW = 1'b0;
   localparam logic MODE_LOAD = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REINIT_MUL,
      ST_REINIT_RED,
      ST_DRAW_MUL,
      ST_DRAW_RED
   } state_type;

   // Access to the shuffle table for one cycle.
   typedef struct packed {
      logic               wr_en;
      logic [IDX_W-1:0]   wr_addr;
      logic [VALUE_W-1:0] wr_data;
      logic               rd_en;
      logic [IDX_W-1:0]   rd_addr;
   } table_req_type;

endpackage

// ===== rtl/core/slrg_mulmod.sv =====
// Shared multiply by 16807 and reduction modulo 2^31-1.
module slrg_mulmod (
   input  logic                           clock,
   input  logic                           start,
   input  logic [slrg_pkg::WORD_W-1:0]    operand,
   output logic [slrg_pkg::VALUE_W-1:0]   result
);
   import slrg_pkg::*;

   logic [PROD_W-1:0] product_ff;
   logic [PROD_W-1:0] product_in;
   logic [WORD_W-1:0] fold_sum;

   // Multiply stage: the product is captured when a step starts and held otherwise.
   assign product_in = start ? (PROD_W'(operand) * PROD_W'(LEHMER_MUL)) : product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   // Reduction stage: 2^31 is 1 modulo 2^31-1, so the high part folds onto the low part.
   // The folded sum stays below twice the modulus, so one subtraction finishes it.
   assign fold_sum = {1'b0, product_ff[VALUE_W-1:0]}
                   + {{(WORD_W-HIGH_W){1'b0}}, product_ff[PROD_W-1:VALUE_W]};

   assign result = (fold_sum >= LEHMER_MOD) ? VALUE_W'(fold_sum - LEHMER_MOD)
                                            : fold_sum[VALUE_W-1:0];

endmodule

// ===== rtl/core/slrg_table.sv =====
// Shuffle table memory with one write port and one registered read port.
module slrg_table (
   input  logic                           clock,
   input  slrg_pkg::table_req_type        table_req,
   output logic [slrg_pkg::VALUE_W-1:0]   rd_data
);
   import slrg_pkg::*;

   logic [VALUE_W-1:0] table_mem_ff [TABLE_SIZE];
   logic [VALUE_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (table_req.wr_en) begin
         table_mem_ff[table_req.wr_addr] <= table_req.wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (table_req.rd_en) begin
         rd_data_ff <= table_mem_ff[table_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/slrg_seq.sv =====
// Sequencer for requests, warm-up steps, table swaps and the result register.
module slrg_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_mode,
   input  logic signed [slrg_pkg::WORD_W-1:0] req_seed_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [slrg_pkg::VALUE_W-1:0]   rsp_random_value,
   output logic                           mul_start,
   output logic [slrg_pkg::WORD_W-1:0]    mul_operand,
   input  logic [slrg_pkg::VALUE_W-1:0]   mul_result,
   output slrg_pkg::table_req_type        table_req,
   input  logic [slrg_pkg::VALUE_W-1:0]   table_rd_data
);
   import slrg_pkg::*;

   state_type          state_ff, state_in;
   logic [WORD_W-1:0]  word_ff, word_in;
   logic [VALUE_W-1:0] last_out_ff, last_out_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic               accept;
   logic               need_reinit;
   logic [WORD_W-1:0]  start_word;
   logic [IDX_W-1:0]   pick;
   logic               rsp_free;

   // Request decode and reinitialization check.
   assign accept      = req_valid && !req_stall;
   assign need_reinit = (word_ff == '0) || word_ff[WORD_W-1] || (last_out_ff == '0);
   assign start_word  = word_ff[WORD_W-1] ? (~word_ff + WORD_W'(1)) : WORD_W'(1);
   assign pick        = last_out_ff[PICK_SHIFT +: IDX_W];
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;

   // The generator word always feeds the shared multiplier.
   assign mul_operand = word_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == MODE_DRAW)) begin
               state_in = need_reinit ? ST_REINIT_MUL : ST_DRAW_RED;
            end
         end
         ST_REINIT_MUL: begin
            state_in = ST_REINIT_RED;
         end
         ST_REINIT_RED: begin
            state_in = (count_ff == '0) ? ST_DRAW_MUL : ST_REINIT_MUL;
         end
         ST_DRAW_MUL: begin
            state_in = ST_DRAW_RED;
         end
         ST_DRAW_RED: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath control and register updates.
   always_comb begin
      word_in           = word_ff;
      last_out_in       = last_out_ff;
      count_in          = count_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_value_in      = rsp_value_ff;
      mul_start         = 1'b0;
      table_req         = '0;
      table_req.wr_data = mul_result;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_LOAD) begin
                  word_in = req_seed_value;
               end else if (need_reinit) begin
                  word_in  = start_word;
                  count_in = CNT_W'(WARMUP_STEPS - 1);
               end else begin
                  mul_start         = 1'b1;
                  table_req.rd_en   = 1'b1;
                  table_req.rd_addr = pick;
               end
            end
         end
         ST_REINIT_MUL: begin
            mul_start = 1'b1;
         end
         ST_REINIT_RED: begin
            // The last TABLE_SIZE warm-up steps fill the table from the top down.
            word_in = {1'b0, mul_result};
            if (count_ff < CNT_W'(TABLE_SIZE)) begin
               table_req.wr_en   = 1'b1;
               table_req.wr_addr = count_ff[IDX_W-1:0];
            end
            if (count_ff == '0) begin
               last_out_in = mul_result;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         ST_DRAW_MUL: begin
            mul_start         = 1'b1;
            table_req.rd_en   = 1'b1;
            table_req.rd_addr = pick;
         end
         ST_DRAW_RED: begin
            // Swap the advanced word into the picked entry and return the old entry.
            if (rsp_free) begin
               word_in           = {1'b0, mul_result};
               last_out_in       = table_rd_data;
               table_req.wr_en   = 1'b1;
               table_req.wr_addr = pick;
               rsp_valid_in      = 1'b1;
               rsp_value_in      = table_rd_data;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         word_ff      <= '0;
         last_out_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         last_out_ff  <= last_out_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;

   // A load request never starts a sequence.
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_mode == MODE_LOAD)) |=> (state_ff == ST_IDLE))
      else $error("load request left the idle state");

   // A draw on a valid generator state goes straight to the swap step.
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_mode == MODE_DRAW) && !need_reinit) |=> (state_ff == ST_DRAW_RED))
      else $error("ordinary draw did not go to the swap step");

   // A result appears only from the swap step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DRAW_RED))
      else $error("result raised outside the swap step");

   // The warm-up counter stays within the step count.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REINIT_RED) |-> (count_ff < CNT_W'(WARMUP_STEPS)))
      else $error("warm-up counter out of range");

   // The swap step waits while the previous result is still held.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DRAW_RED) && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_DRAW_RED))
      else $error("swap step overran a pending result");

endmodule

// ===== rtl/core/shuffled_lehmer_random_generator_top.sv =====
// A load request sets the generator word; a draw returns its result from a register.
// A reinitializing draw first runs 40 warm-up steps, each a multiply and a reduce state.
// The block takes no request while a draw is in progress.
// Reset is synchronous and active high; it clears the generator word and last output,
// so the first draw reinitializes. The shuffle table needs no clearing.
module shuffled_lehmer_random_generator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_mode,
   input  logic signed [slrg_pkg::WORD_W-1:0]  req_seed_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [slrg_pkg::VALUE_W-1:0]        rsp_random_value
);
   import slrg_pkg::*;

   logic               mul_start;
   logic [WORD_W-1:0]  mul_operand;
   logic [VALUE_W-1:0] mul_result;
   table_req_type      table_req;
   logic [VALUE_W-1:0] table_rd_data;

   // Sequencer.
   slrg_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_seed_value   (req_seed_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_random_value (rsp_random_value),
      .mul_start        (mul_start),
      .mul_operand      (mul_operand),
      .mul_result       (mul_result),
      .table_req        (table_req),
      .table_rd_data    (table_rd_data)
   );

   // Shared modular multiplier.
   slrg_mulmod u_mulmod (
      .clock   (clock),
      .start   (mul_start),
      .operand (mul_operand),
      .result  (mul_result)
   );

   // Shuffle table.
   slrg_table u_table (
      .clock     (clock),
      .table_req (table_req),
      .rd_data   (table_rd_data)
   );

endmodule
